### src/bpss_pkg.sv
package bpss_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_WAIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FAULT_HOLD     = 2'd1;

  localparam logic [15:0] FAULT_HOLD_RESET = 16'd1000;

  // Mode codes as seen on the result
  localparam logic [2:0] MODE_CODE_STARTUP   = 3'd0;
  localparam logic [2:0] MODE_CODE_WELDCHECK = 3'd1;
  localparam logic [2:0] MODE_CODE_WELDED    = 3'd2;
  localparam logic [2:0] MODE_CODE_ACTIVE    = 3'd3;
  localparam logic [2:0] MODE_CODE_CHARGING  = 3'd4;
  localparam logic [2:0] MODE_CODE_FAULTED   = 3'd5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // Internal mode register, one-hot
  typedef enum logic [5:0] {
    MODE_STARTUP   = 6'b000001,
    MODE_WELDCHECK = 6'b000010,
    MODE_WELDED    = 6'b000100,
    MODE_ACTIVE    = 6'b001000,
    MODE_CHARGING  = 6'b010000,
    MODE_FAULTED   = 6'b100000
  } mode_t;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic        charge_request;
    logic        contactor_stuck;
    logic        imd_fault;
    logic        bms_fault;
    logic        shutdown_ok;
    logic [31:0] now_ms;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic       mode_changed;
    logic       wdog_disable;
    logic       wdog_reinit;
    logic       balance_off;
    logic       balance_on;
    logic       latch_en_low;
    logic       latch_en_high;
    logic       pin_not_ok_low;
    logic       pin_not_ok_high;
    logic [2:0] mode_now;
  } out_item_t;

  function automatic logic [2:0] mode_code(input mode_t m);
    logic [2:0] c;
    c = MODE_CODE_STARTUP;
    unique case (m)
      MODE_STARTUP:   c = MODE_CODE_STARTUP;
      MODE_WELDCHECK: c = MODE_CODE_WELDCHECK;
      MODE_WELDED:    c = MODE_CODE_WELDED;
      MODE_ACTIVE:    c = MODE_CODE_ACTIVE;
      MODE_CHARGING:  c = MODE_CODE_CHARGING;
      MODE_FAULTED:   c = MODE_CODE_FAULTED;
      default:        c = MODE_CODE_STARTUP;
    endcase
    return c;
  endfunction

endpackage

### src/bpss_next.sv
module bpss_next
  import bpss_pkg::*;
(
  input  mode_t       mode,
  input  logic [31:0] last_change_ms,
  input  logic [15:0] precharge_wait_ms,
  input  logic [15:0] fault_hold_ms,
  input  in_item_t    item,
  output mode_t       mode_nxt,
  output out_item_t   res
);

  logic [31:0] elapsed;
  logic        fault;
  logic        precharge_done;
  logic        hold_done;
  logic        change;
  logic        hold_reinit;

  // Wrapping elapsed time since the last mode change
  assign elapsed        = item.now_ms - last_change_ms;
  assign fault          = item.bms_fault | item.imd_fault;
  assign precharge_done = elapsed > {16'd0, precharge_wait_ms};
  assign hold_done      = elapsed > {16'd0, fault_hold_ms};

  // Transition selection, first match wins within each mode
  always_comb begin
    mode_nxt    = mode;
    change      = 1'b0;
    hold_reinit = 1'b0;
    unique case (mode)
      MODE_STARTUP: begin
        if (precharge_done && item.shutdown_ok) begin
          mode_nxt = MODE_WELDCHECK;
          change   = 1'b1;
        end else if (fault) begin
          mode_nxt = MODE_FAULTED;
          change   = 1'b1;
        end
      end
      MODE_WELDCHECK: begin
        if (precharge_done) begin
          mode_nxt = item.contactor_stuck ? MODE_WELDED : MODE_ACTIVE;
          change   = 1'b1;
        end
      end
      MODE_WELDED: begin
        if (fault) begin
          mode_nxt = MODE_FAULTED;
          change   = 1'b1;
        end
      end
      MODE_ACTIVE: begin
        if (item.charge_request) begin
          mode_nxt = MODE_CHARGING;
          change   = 1'b1;
        end else if (fault) begin
          mode_nxt = MODE_FAULTED;
          change   = 1'b1;
        end else if (!item.shutdown_ok) begin
          mode_nxt = MODE_STARTUP;
          change   = 1'b1;
        end
      end
      MODE_CHARGING: begin
        if (!item.charge_request) begin
          mode_nxt = MODE_ACTIVE;
          change   = 1'b1;
        end else if (fault) begin
          mode_nxt = MODE_FAULTED;
          change   = 1'b1;
        end else if (!item.shutdown_ok) begin
          mode_nxt = MODE_STARTUP;
          change   = 1'b1;
        end
      end
      MODE_FAULTED: begin
        hold_reinit = hold_done && !item.bms_fault;
        if (item.shutdown_ok && !fault) begin
          mode_nxt = MODE_STARTUP;
          change   = 1'b1;
        end
      end
      default: begin
        mode_nxt = mode;
      end
    endcase
  end

  // Result: new mode code, change flag, exit and entry pulses, watchdog reinit
  always_comb begin
    res                 = '0;
    res.mode_now        = mode_code(mode_nxt);
    res.mode_changed    = change;
    res.balance_off     = change && (mode == MODE_CHARGING);
    res.latch_en_high   = change && (mode == MODE_FAULTED);
    res.pin_not_ok_high = change && (mode_nxt == MODE_STARTUP || mode_nxt == MODE_WELDED);
    res.pin_not_ok_low  = change && (mode_nxt == MODE_ACTIVE);
    res.balance_on      = change && (mode_nxt == MODE_CHARGING);
    res.wdog_disable    = change && (mode_nxt == MODE_FAULTED);
    res.latch_en_low    = change && (mode_nxt == MODE_FAULTED);
    res.wdog_reinit     = hold_reinit
                        | (change && (mode == MODE_FAULTED))
                        | (change && (mode_nxt == MODE_STARTUP));
  end

endmodule

### src/battery_pack_safety_sequencer_core.sv
// Pipeline: input register, then result register; while the result register is full and
// out_tready is low, the item waits in the input register.
// Throughput: one tick per cycle while the result stream is not stalled by out_tready.
// Reset (rst_n low, synchronous): mode startup, last change time 0, precharge wait 0,
// fault hold 1000 ms, both stages empty.
module battery_pack_safety_sequencer_core
  import bpss_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [15:0]           cfg_data,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] now_ms, [32] shutdown_ok, [33] bms_fault, [34] imd_fault,
  // [35] contactor_stuck, [36] charge_request, [39:37] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [2:0] mode_now, [3] pin_not_ok_high, [4] pin_not_ok_low, [5] latch_en_high,
  // [6] latch_en_low, [7] balance_on, [8] balance_off, [9] wdog_reinit,
  // [10] wdog_disable, [11] mode_changed, [15:12] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic [15:0] precharge_wait_r;
  logic [15:0] fault_hold_r;
  mode_t       mode_r;
  mode_t       mode_nxt;
  logic [31:0] last_change_r;
  in_item_t    in_r;
  logic        in_vld_r;
  out_item_t   out_r;
  out_item_t   res;
  logic        out_vld_r;
  logic        advance;
  logic        fire;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      precharge_wait_r <= '0;
      fault_hold_r     <= FAULT_HOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PRECHARGE_WAIT) precharge_wait_r <= cfg_data;
      if (cfg_index == REG_FAULT_HOLD)     fault_hold_r     <= cfg_data;
    end
  end

  // Pipeline flow: result stage frees up when empty or taken
  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= in_item_t'(in_tdata[$bits(in_item_t)-1:0]);
    end
  end

  bpss_next u_next (
    .mode              (mode_r),
    .last_change_ms    (last_change_r),
    .precharge_wait_ms (precharge_wait_r),
    .fault_hold_ms     (fault_hold_r),
    .item              (in_r),
    .mode_nxt          (mode_nxt),
    .res               (res)
  );

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_STARTUP;
      last_change_r <= '0;
    end else if (fire && res.mode_changed) begin
      mode_r        <= mode_nxt;
      last_change_r <= in_r.now_ms;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(OUT_DATA_W - $bits(out_item_t)){1'b0}}, out_r};

`ifndef NO_ASSERTIONS
  // A mode change records the tick's timestamp
  a_last_change: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res.mode_changed |=> last_change_r == $past(in_r.now_ms))
    else $error("last change time not updated on mode change");

  // The reported mode matches the held mode
  a_mode_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_r.mode_now == mode_code(mode_r))
    else $error("result mode differs from sequencer mode");

  // Entry and exit pulses only come with a mode change
  a_pulse_change: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_r.mode_changed |->
      !(out_r.pin_not_ok_high || out_r.pin_not_ok_low || out_r.latch_en_high ||
        out_r.latch_en_low || out_r.balance_on || out_r.balance_off ||
        out_r.wdog_disable))
    else $error("action pulse without mode change");

  // A held item waits in the input register while the result stage is stalled
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_r))
    else $error("input item lost during stall");
`endif

endmodule
